@@ design/ising2d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising2d_pkg
// Types and constants shared by the Ising lattice update block.
// ----------------------------------------------------------------------------
package ising2d_pkg;

	localparam int IN_W     = 7;    // row and column port width
	localparam int SIDE_W   = 8;    // side length and wrapped index width
	localparam int VAL_W    = 16;   // thresholds, random fraction, counters
	localparam int SQ_W     = 16;   // side squared and attempt counter
	localparam int E_W      = 17;   // energy width
	localparam int M_W      = 16;   // magnetisation width
	localparam int CIDX_W   = 3;    // configuration index width

	// Largest lattice side; the port, counter and energy widths are sized for it.
	localparam int MAX_SIDE = 128;

	localparam logic [SIDE_W-1:0] SIDE_MIN = 8'd2;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_THR4   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_THR8   = 3'd1;
	localparam logic [CIDX_W-1:0] REG_SIDE   = 3'd2;
	localparam logic [CIDX_W-1:0] REG_STEPS  = 3'd3;
	localparam logic [CIDX_W-1:0] REG_BURN   = 3'd4;
	localparam logic [CIDX_W-1:0] REG_GAP    = 3'd5;

	// Reset values of the configuration registers
	localparam logic [VAL_W-1:0]  THR_RST    = 16'd0;
	localparam logic [SIDE_W-1:0] SIDE_RST   = 8'd100;
	localparam logic [VAL_W-1:0]  STEPS_RST  = 16'd10000;
	localparam logic [VAL_W-1:0]  BURN_RST   = 16'd1000;
	localparam logic [VAL_W-1:0]  GAP_RST    = 16'd10;

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	// One classified flip request as it waits in the queue
	typedef struct packed {
		logic              bad;
		logic [SIDE_W-1:0] row;
		logic [SIDE_W-1:0] col;
		logic [SIDE_W-1:0] row_p;
		logic [SIDE_W-1:0] row_m;
		logic [SIDE_W-1:0] col_p;
		logic [SIDE_W-1:0] col_m;
		logic [VAL_W-1:0]  rand16;
	} attempt_t;

	// Run settings handed to the back part
	typedef struct packed {
		logic [VAL_W-1:0] thr4;
		logic [VAL_W-1:0] thr8;
		logic [VAL_W-1:0] total_steps;
		logic [VAL_W-1:0] burn_in;
		logic [VAL_W-1:0] gap_len;
		logic [SQ_W-1:0]  side_sq;
	} run_cfg_t;

endpackage

@@ design/ising2d_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising2d_fifo
// Short request queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module ising2d_fifo import ising2d_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  attempt_t wr_entry,
	input  logic     pop,
	output attempt_t rd_entry,
	output logic     full,
	output logic     empty
);

	attempt_t         entries_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_CW-1:0]  count_q;

	assign full     = (count_q == Q_CW'(Q_DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/ising2d_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising2d_front
// Accepts flip requests, checks the site against the lattice and works out
// the wrapped neighbour indexes and the aligned random fraction.
// ----------------------------------------------------------------------------
module ising2d_front import ising2d_pkg::*; #(
	parameter int RAND_BITS = 16
) (
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [IN_W-1:0]      row,
	input  logic [IN_W-1:0]      col,
	input  logic [RAND_BITS-1:0] rand_value,
	input  logic [SIDE_W-1:0]    side_use,
	input  logic                 clearing,
	input  logic                 q_full,
	output logic                 push,
	output attempt_t             entry
);

	logic [SIDE_W-1:0] r8;
	logic [SIDE_W-1:0] c8;
	logic [SIDE_W-1:0] r_inc;
	logic [SIDE_W-1:0] c_inc;
	logic [VAL_W-1:0]  rand16;

	generate
		if (RAND_BITS >= VAL_W) begin : g_rand_trunc
			assign rand16 = rand_value[RAND_BITS-1 -: VAL_W];
		end else begin : g_rand_widen
			assign rand16 = {rand_value, {(VAL_W-RAND_BITS){1'b0}}};
		end
	endgenerate

	assign in_stall = clearing || q_full;
	assign push     = in_valid && !in_stall;

	always_comb begin
		r8    = {1'b0, row};
		c8    = {1'b0, col};
		r_inc = r8 + 8'd1;
		c_inc = c8 + 8'd1;

		entry.bad    = (r8 >= side_use) || (c8 >= side_use);
		entry.row    = r8;
		entry.col    = c8;
		entry.row_p  = (r_inc == side_use) ? '0 : r_inc;
		entry.row_m  = (r8 == '0) ? side_use - 8'd1 : r8 - 8'd1;
		entry.col_p  = (c_inc == side_use) ? '0 : c_inc;
		entry.col_m  = (c8 == '0) ? side_use - 8'd1 : c8 - 8'd1;
		entry.rand16 = rand16;
	end

endmodule

@@ design/ising2d_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising2d_back
// Owns the spin lattice memory, runs the read-modify-write of each flip
// request, keeps the run counters and holds the result register.
// ----------------------------------------------------------------------------
module ising2d_back import ising2d_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   restart,
	input  run_cfg_t               cfg,
	input  attempt_t               head,
	input  logic                   q_empty,
	output logic                   pop,
	output logic                   clearing,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   flipped,
	output logic                   bad_site,
	output logic                   sample_valid,
	output logic [VAL_W-1:0]       sweep_index,
	output logic signed [E_W-1:0]  energy,
	output logic signed [M_W-1:0]  magnetization,
	output logic                   run_done
);

	localparam int IDX_W = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD2  = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0]            state_q;
	attempt_t              cur_q;
	logic                  south_q;

	logic [MAX_SIDE-1:0]   spin_mem [MAX_SIDE];
	logic [MAX_SIDE-1:0]   rdata_a_q;
	logic [MAX_SIDE-1:0]   rdata_b_q;
	logic                  rd_a_en;
	logic                  rd_b_en;
	logic [IDX_W-1:0]      rd_a_addr;
	logic [IDX_W-1:0]      rd_b_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [MAX_SIDE-1:0]   wdata;

	logic                  clear_busy_q;
	logic [IDX_W-1:0]      clr_row_q;

	logic [SQ_W-1:0]       attempt_q;
	logic [VAL_W-1:0]      sweep_q;
	logic [VAL_W-1:0]      gap_q;
	logic signed [E_W-1:0] energy_q;
	logic signed [M_W-1:0] magnet_q;
	logic                  done_q;

	logic                  out_valid_q;
	logic                  out_free;
	logic                  exec_go;
	logic                  head_counted;
	logic                  counted;

	logic [IDX_W-1:0]      c_i;
	logic                  s_bit;
	logic [2:0]            aligned;
	logic signed [E_W-1:0] de;
	logic                  flip;
	logic [SQ_W-1:0]       attempt_inc;
	logic                  end_sweep;
	logic [VAL_W:0]        sweep_inc;
	logic [VAL_W-1:0]      gap_val;
	logic                  sampled;

	assign clearing     = clear_busy_q;
	assign out_valid    = out_valid_q;
	assign out_free     = !out_valid_q || !out_stall;
	assign head_counted = !head.bad && !done_q;
	assign counted      = !cur_q.bad && !done_q;
	assign pop          = (state_q == ST_IDLE) && !q_empty && !clear_busy_q;
	assign exec_go      = (state_q == ST_EXEC) && out_free;

	// Row r and row r+1 are read together, row r-1 in the following cycle.
	always_comb begin
		rd_a_en   = pop && head_counted;
		rd_a_addr = IDX_W'(head.row);
		rd_b_en   = rd_a_en || (state_q == ST_RD2);
		rd_b_addr = (state_q == ST_RD2) ? IDX_W'(cur_q.row_m) : IDX_W'(head.row_p);
	end

	// Flip decision on the spin and its four neighbours
	always_comb begin
		c_i     = IDX_W'(cur_q.col);
		s_bit   = rdata_a_q[c_i];
		aligned = {2'b00, rdata_b_q[c_i] ~^ s_bit}
			+ {2'b00, south_q ~^ s_bit}
			+ {2'b00, rdata_a_q[IDX_W'(cur_q.col_p)] ~^ s_bit}
			+ {2'b00, rdata_a_q[IDX_W'(cur_q.col_m)] ~^ s_bit};
		case (aligned)
			3'd4:    de = 17'sd8;
			3'd3:    de = 17'sd4;
			3'd2:    de = 17'sd0;
			3'd1:    de = -17'sd4;
			default: de = -17'sd8;
		endcase
		if (aligned == 3'd4) begin
			flip = cur_q.rand16 < cfg.thr8;
		end else if (aligned == 3'd3) begin
			flip = cur_q.rand16 < cfg.thr4;
		end else begin
			flip = 1'b1;
		end
		flip = flip && counted;

		wdata      = rdata_a_q;
		wdata[c_i] = ~s_bit;
		wr_en      = exec_go && flip;
		wr_addr    = IDX_W'(cur_q.row);

		attempt_inc = attempt_q + 16'd1;
		end_sweep   = counted && (attempt_inc >= cfg.side_sq);
		sweep_inc   = {1'b0, sweep_q} + 17'd1;
		gap_val     = (cfg.gap_len == '0) ? 16'd1 : cfg.gap_len;
		sampled     = end_sweep && (sweep_q >= cfg.burn_in) && (gap_q == '0);
	end

	// Lattice memory: the clearing pass sets every spin to +1.
	always_ff @(posedge clk) begin
		if (clear_busy_q) begin
			spin_mem[clr_row_q] <= '1;
		end else if (wr_en) begin
			spin_mem[wr_addr] <= wdata;
		end
		if (rd_a_en) begin
			rdata_a_q <= spin_mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rdata_b_q <= spin_mem[rd_b_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (state_q == ST_RD2) begin
			south_q <= rdata_b_q[c_i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clr_row_q    <= '0;
		end else if (restart) begin
			clear_busy_q <= 1'b1;
			clr_row_q    <= '0;
		end else if (clear_busy_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == IDX_W'(MAX_SIDE - 1)) begin
				clear_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= head_counted ? ST_RD2 : ST_EXEC;
					end
				end
				ST_RD2: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Run counters are held at their start values for the whole clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_q <= '0;
			sweep_q   <= '0;
			gap_q     <= '0;
			energy_q  <= '0;
			magnet_q  <= '0;
			done_q    <= 1'b0;
		end else if (clear_busy_q) begin
			attempt_q <= '0;
			sweep_q   <= '0;
			gap_q     <= '0;
			energy_q  <= 17'sd0 - $signed({cfg.side_sq, 1'b0});
			magnet_q  <= $signed(cfg.side_sq);
			done_q    <= (cfg.total_steps == '0);
		end else if (exec_go && counted) begin
			if (flip) begin
				energy_q <= energy_q + de;
				magnet_q <= s_bit ? magnet_q - 16'sd2 : magnet_q + 16'sd2;
			end
			if (end_sweep) begin
				attempt_q <= '0;
				sweep_q   <= sweep_inc[VAL_W-1:0];
				if (sweep_q >= cfg.burn_in) begin
					gap_q <= (gap_q == '0) ? gap_val - 16'd1 : gap_q - 16'd1;
				end
				if (sweep_inc >= {1'b0, cfg.total_steps}) begin
					done_q <= 1'b1;
				end
			end else begin
				attempt_q <= attempt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			flipped       <= flip;
			bad_site      <= cur_q.bad;
			sample_valid  <= sampled;
			sweep_index   <= sweep_q;
			energy        <= flip ? energy_q + de : energy_q;
			magnetization <= !flip ? magnet_q
				: (s_bit ? magnet_q - 16'sd2 : magnet_q + 16'sd2);
			run_done      <= done_q
				|| (end_sweep && (sweep_inc >= {1'b0, cfg.total_steps}));
		end
	end

endmodule

@@ design/ising_2d_metropolis_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_2d_metropolis_update
// Metropolis spin flip engine for a square Ising lattice with periodic wrap.
// ----------------------------------------------------------------------------
// Each request on the input channel (in_valid / in_stall) is one flip attempt
// at (row, col) with a uniform random fraction. Exactly one result leaves on
// the output channel (out_valid / out_stall) per request, in request order,
// carrying the flip outcome, the running energy and magnetisation, the sweep
// index and the sample and run-finished flags.
// A lattice-site request goes from the idle state through the second-read
// state to the execute state, where it is written back; a site outside the
// lattice or a request after the run has finished skips the second read.
// The lattice memory sets the pace: row r and row r+1 are read together,
// row r-1 in the next cycle, and row r is written back in the execute state
// once the output register is free. A four-entry queue keeps taking requests
// until full while the back part works or the receiver stalls; a stalled
// result holds in the output register.
// After reset and after a write to one of the six configuration registers
// (cfg_valid / cfg_ready, always ready), every spin is set to +1 by a clearing
// pass over all MAX_SIDE rows while in_stall is high and the run restarts.
// ----------------------------------------------------------------------------
module ising_2d_metropolis_update import ising2d_pkg::*; #(
	parameter int RAND_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CIDX_W-1:0]      cfg_index,
	input  logic [VAL_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [IN_W-1:0]        row,
	input  logic [IN_W-1:0]        col,
	input  logic [RAND_BITS-1:0]   rand_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   flipped,
	output logic                   bad_site,
	output logic                   sample_valid,
	output logic [VAL_W-1:0]       sweep_index,
	output logic signed [E_W-1:0]  energy,
	output logic signed [M_W-1:0]  magnetization,
	output logic                   run_done
);

	localparam int SIDE_CAP = (MAX_SIDE > 255) ? 255 : MAX_SIDE;

	logic [VAL_W-1:0]  thr4_q;
	logic [VAL_W-1:0]  thr8_q;
	logic [SIDE_W-1:0] side_len_q;
	logic [VAL_W-1:0]  steps_q;
	logic [VAL_W-1:0]  burn_q;
	logic [VAL_W-1:0]  gap_q;
	logic [SQ_W-1:0]   side_sq_q;
	logic [SIDE_W-1:0] side_use;
	logic              cfg_wr;
	logic              restart;
	run_cfg_t          run_cfg;

	attempt_t          q_wr_entry;
	attempt_t          q_rd_entry;
	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;
	logic              clearing;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		if (side_len_q < SIDE_MIN) begin
			side_use = SIDE_MIN;
		end else if (side_len_q > SIDE_W'(SIDE_CAP)) begin
			side_use = SIDE_W'(SIDE_CAP);
		end else begin
			side_use = side_len_q;
		end
	end

	always_comb begin
		case (cfg_index) inside
			REG_THR4, REG_THR8, REG_SIDE, REG_STEPS, REG_BURN, REG_GAP: begin
				restart = cfg_wr;
			end
			default: begin
				restart = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr4_q     <= THR_RST;
			thr8_q     <= THR_RST;
			side_len_q <= SIDE_RST;
			steps_q    <= STEPS_RST;
			burn_q     <= BURN_RST;
			gap_q      <= GAP_RST;
			side_sq_q  <= '0;
		end else begin
			side_sq_q <= {8'd0, side_use} * {8'd0, side_use};
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_THR4:  thr4_q     <= cfg_data;
					REG_THR8:  thr8_q     <= cfg_data;
					REG_SIDE:  side_len_q <= cfg_data[SIDE_W-1:0];
					REG_STEPS: steps_q    <= cfg_data;
					REG_BURN:  burn_q     <= cfg_data;
					REG_GAP:   gap_q      <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		run_cfg.thr4        = thr4_q;
		run_cfg.thr8        = thr8_q;
		run_cfg.total_steps = steps_q;
		run_cfg.burn_in     = burn_q;
		run_cfg.gap_len     = gap_q;
		run_cfg.side_sq     = side_sq_q;
	end

	ising2d_front #(
		.RAND_BITS (RAND_BITS)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.row        (row),
		.col        (col),
		.rand_value (rand_value),
		.side_use   (side_use),
		.clearing   (clearing),
		.q_full     (q_full),
		.push       (q_push),
		.entry      (q_wr_entry)
	);

	ising2d_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.pop      (q_pop),
		.rd_entry (q_rd_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	ising2d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (restart),
		.cfg           (run_cfg),
		.head          (q_rd_entry),
		.q_empty       (q_empty),
		.pop           (q_pop),
		.clearing      (clearing),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.flipped       (flipped),
		.bad_site      (bad_site),
		.sample_valid  (sample_valid),
		.sweep_index   (sweep_index),
		.energy        (energy),
		.magnetization (magnetization),
		.run_done      (run_done)
	);

endmodule
